// File: sv/mbrs_pkg.sv
package mbrs_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned TABLE_ENTRIES_DEF      = 256;
  localparam int unsigned RX_BYTES_DEF           = 256;
  localparam int unsigned MAX_RESPONSE_BYTES_DEF = 64;

  // Input commands.
  localparam logic [2:0] CMD_RX_BYTE      = 3'd0;
  localparam logic [2:0] CMD_FRAME_GAP    = 3'd1;
  localparam logic [2:0] CMD_SET_INPUT    = 3'd2;
  localparam logic [2:0] CMD_SET_DISCRETE = 3'd3;
  localparam logic [2:0] CMD_READ_HOLDING = 3'd4;
  localparam logic [2:0] CMD_READ_COIL    = 3'd5;

  // Modbus function codes.
  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

  // Configuration register indexes.
  localparam logic [7:0] REG_STATION = 8'd0;
  localparam logic [7:0] REG_CRC_EN  = 8'd1;

  // CRC-16 as used on the line: reflected polynomial, all-ones start.
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef struct packed {
    logic       init;
    logic       load;
    logic       step;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

// File: sv/mbrs_crc.sv
module mbrs_crc
  import mbrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  crc_ctrl_t   ctrl_i,
  output logic [15:0] crc_o
);

  logic [15:0] crc_q;
  logic [15:0] crc_d;

  // Fold in a byte, then shift one bit per step.
  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = CRC_INIT;
    end else if (ctrl_i.load) begin
      crc_d = crc_q ^ {8'h00, ctrl_i.data};
    end else if (ctrl_i.step) begin
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// File: sv/modbus_rtu_slave_engine.sv
// Modbus RTU slave engine. Raise start_i with a command while busy_o is low;
// the command is taken at that edge. Received bytes (command 0) and local table
// writes (commands 2, 3) finish in the accepting cycle; local reads (4, 5)
// return their word through the registered table read and S_LOCAL. A frame
// gap (command 1) runs a sequencer that reuses a single bit-serial CRC unit,
// shifting each frame byte ahead of the received CRC through it bit by bit
// to check it, then each response byte sent with a new CRC. Table bits, echoed
// bytes and code 15 coils take a request and a use state, code 16 registers
// two such pairs; busy_o stays high throughout. Results appear on
// result_valid_o for one cycle each and cannot be held off, so the receiver
// must take every word as it comes. After reset the four tables are swept to
// zero, one entry per cycle, while busy_o is high. Configuration writes are
// always accepted and must only be issued while the engine is idle.
module modbus_rtu_slave_engine
  import mbrs_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES      = TABLE_ENTRIES_DEF,
  parameter int unsigned RX_BYTES           = RX_BYTES_DEF,
  parameter int unsigned MAX_RESPONSE_BYTES = MAX_RESPONSE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  address_i,
  input  logic [15:0] value_i,
  output logic        result_valid_o,
  output logic        kind_o,
  output logic [15:0] payload_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned TW = $clog2(TABLE_ENTRIES);
  localparam int unsigned AW = $clog2(RX_BYTES);
  localparam int unsigned FW = $clog2(RX_BYTES + 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOCAL, S_SCAN_REQ, S_SCAN_USE, S_CRC, S_CHECK,
    S_HDR, S_EMIT, S_BIT_REQ, S_BIT_USE, S_WORD_REQ, S_WORD_USE, S_WORD_LO,
    S_CRC_LO, S_CRC_HI, S_SINGLE_WR, S_ECHO_REQ, S_ECHO_USE,
    S_MW_REQ, S_MW_USE, S_MW_REQ2, S_MW_USE2, S_MW_HDR, S_DONE
  } state_e;

  state_e state_q, ret_q;

  // Configuration.
  logic [7:0] station_q;
  logic       crc_en_q;

  // Frame store bookkeeping.
  logic [FW-1:0] fill_q;
  logic          ovf_q;

  // Sequencer working registers.
  logic [TW-1:0] clr_q;
  logic [FW-1:0] k_q;
  logic [7:0]    hdr_q [6];
  logic [15:0]   got_q;
  logic [16:0]   i_q;
  logic [2:0]    bit_q;
  logic [2:0]    step_q;
  logic [7:0]    byte_q;
  logic [15:0]   word_q;
  logic          rd_ok_q;
  logic          fb_ok_q;
  logic          lcl_hold_q;

  // Result word.
  logic        res_valid_q;
  logic        kind_q;
  logic [15:0] payload_q;
  logic        last_q;

  // Memories.
  logic [15:0] hold_mem [TABLE_ENTRIES];
  logic [15:0] in_mem   [TABLE_ENTRIES];
  logic        coil_mem [TABLE_ENTRIES];
  logic        disc_mem [TABLE_ENTRIES];
  logic [7:0]  rx_mem   [RX_BYTES];

  logic [15:0] hold_rd_q, in_rd_q;
  logic        coil_rd_q, disc_rd_q;
  logic [7:0]  rx_rd_q;

  logic          hold_we, in_we, coil_we, disc_we, rx_we;
  logic [15:0]   hold_wd, in_wd;
  logic          coil_wd, disc_wd;
  logic [TW-1:0] tab_wa;
  logic [AW-1:0] rx_wa, rx_ra;

  crc_ctrl_t   crc_ctrl;
  logic [15:0] crc;

  // Frame header fields.
  logic [7:0]  code;
  logic [15:0] start_w, cnt_w;
  assign code    = hdr_q[1];
  assign start_w = {hdr_q[2], hdr_q[3]};
  assign cnt_w   = {hdr_q[4], hdr_q[5]};

  logic [16:0] cnt_p7;
  logic [13:0] nb;
  assign cnt_p7 = {1'b0, cnt_w} + 17'd7;
  assign nb     = cnt_p7[16:3];

  // Pair swap: partner register when it exists, else the register itself.
  logic [16:0] i_x1, j_w;
  assign i_x1 = i_q ^ 17'd1;
  assign j_w  = (i_x1 < {1'b0, cnt_w}) ? i_x1 : i_q;

  // Shared table index and its range check.
  logic [15:0] tidx;
  logic        tok;
  always_comb begin
    case (state_q)
      S_BIT_REQ, S_MW_USE, S_MW_USE2: tidx = start_w + i_q[15:0];
      S_WORD_REQ:                     tidx = start_w + j_w[15:0];
      S_SINGLE_WR:                    tidx = start_w;
      default:                        tidx = {8'h00, address_i};
    endcase
  end
  assign tok = {1'b0, tidx} < 17'(TABLE_ENTRIES);

  // Frame byte index for the multiple-write codes.
  logic [17:0] fidx;
  logic        fok;
  always_comb begin
    if (code == FC_WRITE_COILS) begin
      fidx = 18'd7 + 18'(i_q >> 3);
    end else if (state_q == S_MW_REQ2) begin
      fidx = 18'd8 + {j_w, 1'b0};
    end else begin
      fidx = 18'd7 + {j_w, 1'b0};
    end
  end
  assign fok = fidx < 18'(fill_q);

  logic accept;
  assign accept = start_i && (state_q == S_IDLE);

  // Memory write and read ports.
  always_comb begin
    hold_we = 1'b0;
    in_we   = 1'b0;
    coil_we = 1'b0;
    disc_we = 1'b0;
    rx_we   = 1'b0;
    hold_wd = 16'h0000;
    in_wd   = value_i;
    coil_wd = 1'b0;
    disc_wd = (value_i != 16'h0000);
    tab_wa  = tidx[TW-1:0];
    rx_wa   = fill_q[AW-1:0];
    rx_ra   = k_q[AW-1:0];
    case (state_q)
      S_CLEAR: begin
        hold_we = 1'b1;
        in_we   = 1'b1;
        coil_we = 1'b1;
        disc_we = 1'b1;
        in_wd   = 16'h0000;
        disc_wd = 1'b0;
        tab_wa  = clr_q;
      end
      S_IDLE: begin
        if (accept) begin
          case (command_i)
            CMD_RX_BYTE:      rx_we   = (fill_q < FW'(RX_BYTES));
            CMD_SET_INPUT:    in_we   = tok;
            CMD_SET_DISCRETE: disc_we = tok;
            default:          ;
          endcase
        end
      end
      S_SINGLE_WR: begin
        coil_we = tok && (code == FC_WRITE_COIL);
        coil_wd = (cnt_w != 16'h0000);
        hold_we = tok && (code == FC_WRITE_REG);
        hold_wd = cnt_w;
      end
      S_MW_REQ, S_MW_REQ2: rx_ra = fidx[AW-1:0];
      S_MW_USE: begin
        coil_we = tok && (code == FC_WRITE_COILS);
        coil_wd = fb_ok_q && rx_rd_q[i_q[2:0]];
      end
      S_MW_USE2: begin
        hold_we = tok;
        hold_wd = {byte_q, fb_ok_q ? rx_rd_q : 8'h00};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hold_we) hold_mem[tab_wa] <= hold_wd;
    hold_rd_q <= hold_mem[tidx[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_we) in_mem[tab_wa] <= in_wd;
    in_rd_q <= in_mem[tidx[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (coil_we) coil_mem[tab_wa] <= coil_wd;
    coil_rd_q <= coil_mem[tidx[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (disc_we) disc_mem[tab_wa] <= disc_wd;
    disc_rd_q <= disc_mem[tidx[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) rx_mem[rx_wa] <= value_i[7:0];
    rx_rd_q <= rx_mem[rx_ra];
  end

  // CRC unit control: fold scanned frame bytes ahead of the received CRC while
  // checking, and every emitted header and data byte on the way out.
  logic scan_feed;
  assign scan_feed = crc_en_q && ({1'b0, k_q} + (FW+1)'(2) < {1'b0, fill_q});

  always_comb begin
    crc_ctrl.init = (accept && (command_i == CMD_FRAME_GAP)) || (state_q == S_CHECK);
    crc_ctrl.load = ((state_q == S_SCAN_USE) && scan_feed) || (state_q == S_EMIT);
    crc_ctrl.step = (state_q == S_CRC);
    crc_ctrl.data = (state_q == S_EMIT) ? byte_q : rx_rd_q;
  end

  mbrs_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc)
  );

  // Configuration port.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= 8'd1;
      crc_en_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_STATION) station_q <= cfg_data_i;
      if (cfg_index_i == REG_CRC_EN)  crc_en_q  <= cfg_data_i[0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= S_IDLE;
      clr_q       <= '0;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      k_q         <= '0;
      i_q         <= '0;
      bit_q       <= '0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
      kind_q      <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      last_q      <= 1'b0;
      kind_q      <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == TW'(TABLE_ENTRIES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (command_i)
              CMD_RX_BYTE: begin
                if (fill_q < FW'(RX_BYTES)) fill_q <= fill_q + 1'b1;
                else                        ovf_q  <= 1'b1;
              end
              CMD_FRAME_GAP: begin
                if (fill_q < FW'(3) || ovf_q) begin
                  state_q <= S_DONE;
                end else begin
                  k_q <= '0;
                  for (int n = 0; n < 6; n++) hdr_q[n] <= 8'h00;
                  state_q <= S_SCAN_REQ;
                end
              end
              CMD_READ_HOLDING, CMD_READ_COIL: begin
                rd_ok_q    <= tok;
                lcl_hold_q <= (command_i == CMD_READ_HOLDING);
                state_q    <= S_LOCAL;
              end
              default: ;
            endcase
          end
        end
        S_LOCAL: begin
          res_valid_q <= 1'b1;
          kind_q      <= 1'b1;
          if (!rd_ok_q)        payload_q <= 16'h0000;
          else if (lcl_hold_q) payload_q <= hold_rd_q;
          else                 payload_q <= {15'h0000, coil_rd_q};
          state_q <= S_IDLE;
        end
        S_SCAN_REQ: state_q <= S_SCAN_USE;
        S_SCAN_USE: begin
          if (k_q < FW'(6)) hdr_q[k_q[2:0]] <= rx_rd_q;
          if (k_q + FW'(2) == fill_q) got_q[7:0]  <= rx_rd_q;
          if (k_q + FW'(1) == fill_q) got_q[15:8] <= rx_rd_q;
          k_q <= k_q + 1'b1;
          if (scan_feed) begin
            step_q  <= '0;
            ret_q   <= S_SCAN_REQ;
            state_q <= S_CRC;
          end else if (k_q + FW'(1) == fill_q) begin
            state_q <= S_CHECK;
          end else begin
            state_q <= S_SCAN_REQ;
          end
        end
        S_CRC: begin
          step_q <= step_q + 1'b1;
          if (step_q == 3'd7) state_q <= ret_q;
        end
        S_CHECK: begin
          k_q <= '0;
          i_q <= '0;
          if ((crc_en_q && crc != got_q) || hdr_q[0] != station_q) begin
            state_q <= S_DONE;
          end else begin
            case (code)
              FC_READ_COILS, FC_READ_DISCRETE: begin
                if (17'(nb) + 17'd5 > 17'(MAX_RESPONSE_BYTES)) state_q <= S_DONE;
                else                                          state_q <= S_HDR;
              end
              FC_READ_HOLDING, FC_READ_INPUT: begin
                if ({1'b0, cnt_w, 1'b0} + 18'd5 > 18'(MAX_RESPONSE_BYTES))
                  state_q <= S_DONE;
                else
                  state_q <= S_HDR;
              end
              FC_WRITE_COIL, FC_WRITE_REG: begin
                if (17'(fill_q) > 17'(MAX_RESPONSE_BYTES)) state_q <= S_DONE;
                else                                     state_q <= S_SINGLE_WR;
              end
              FC_WRITE_COILS, FC_WRITE_REGS: begin
                if (cnt_w == 16'h0000) state_q <= S_MW_HDR;
                else                   state_q <= S_MW_REQ;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_HDR: begin
          if (k_q == FW'(0))      byte_q <= hdr_q[0];
          else if (k_q == FW'(1)) byte_q <= code;
          else if (code == FC_READ_COILS || code == FC_READ_DISCRETE) byte_q <= nb[7:0];
          else                    byte_q <= {cnt_w[6:0], 1'b0};
          k_q <= k_q + 1'b1;
          if (k_q != FW'(2))      ret_q <= S_HDR;
          else if (cnt_w == 16'h0000) ret_q <= S_CRC_LO;
          else if (code == FC_READ_COILS || code == FC_READ_DISCRETE) ret_q <= S_BIT_REQ;
          else                    ret_q <= S_WORD_REQ;
          bit_q   <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          res_valid_q <= 1'b1;
          payload_q   <= {8'h00, byte_q};
          step_q      <= '0;
          state_q     <= S_CRC;
        end
        S_BIT_REQ: begin
          rd_ok_q <= tok && (i_q < {1'b0, cnt_w});
          state_q <= S_BIT_USE;
        end
        S_BIT_USE: begin
          byte_q[bit_q] <= rd_ok_q && ((code == FC_READ_COILS) ? coil_rd_q : disc_rd_q);
          i_q   <= i_q + 1'b1;
          bit_q <= bit_q + 1'b1;
          if (bit_q == 3'd7) begin
            ret_q   <= (i_q + 17'd1 >= {1'b0, cnt_w}) ? S_CRC_LO : S_BIT_REQ;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_BIT_REQ;
          end
        end
        S_WORD_REQ: begin
          rd_ok_q <= tok;
          state_q <= S_WORD_USE;
        end
        S_WORD_USE: begin
          if (!rd_ok_q) begin
            word_q <= 16'h0000;
            byte_q <= 8'h00;
          end else if (code == FC_READ_HOLDING) begin
            word_q <= hold_rd_q;
            byte_q <= hold_rd_q[15:8];
          end else begin
            word_q <= in_rd_q;
            byte_q <= in_rd_q[15:8];
          end
          ret_q   <= S_WORD_LO;
          state_q <= S_EMIT;
        end
        S_WORD_LO: begin
          byte_q  <= word_q[7:0];
          i_q     <= i_q + 1'b1;
          ret_q   <= (i_q + 17'd1 == {1'b0, cnt_w}) ? S_CRC_LO : S_WORD_REQ;
          state_q <= S_EMIT;
        end
        S_CRC_LO: begin
          res_valid_q <= 1'b1;
          payload_q   <= {8'h00, crc[7:0]};
          state_q     <= S_CRC_HI;
        end
        S_CRC_HI: begin
          res_valid_q <= 1'b1;
          payload_q   <= {8'h00, crc[15:8]};
          last_q      <= 1'b1;
          state_q     <= S_DONE;
        end
        S_SINGLE_WR: state_q <= S_ECHO_REQ;
        S_ECHO_REQ:  state_q <= S_ECHO_USE;
        S_ECHO_USE: begin
          res_valid_q <= 1'b1;
          payload_q   <= {8'h00, rx_rd_q};
          k_q         <= k_q + 1'b1;
          if (k_q + FW'(1) == fill_q) begin
            last_q  <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_ECHO_REQ;
          end
        end
        S_MW_REQ: begin
          fb_ok_q <= fok;
          state_q <= S_MW_USE;
        end
        S_MW_USE: begin
          if (code == FC_WRITE_COILS) begin
            i_q     <= i_q + 1'b1;
            state_q <= (i_q + 17'd1 == {1'b0, cnt_w}) ? S_MW_HDR : S_MW_REQ;
          end else begin
            byte_q  <= fb_ok_q ? rx_rd_q : 8'h00;
            state_q <= S_MW_REQ2;
          end
        end
        S_MW_REQ2: begin
          fb_ok_q <= fok;
          state_q <= S_MW_USE2;
        end
        S_MW_USE2: begin
          i_q     <= i_q + 1'b1;
          state_q <= (i_q + 17'd1 == {1'b0, cnt_w}) ? S_MW_HDR : S_MW_REQ;
        end
        S_MW_HDR: begin
          byte_q  <= hdr_q[k_q[2:0]];
          k_q     <= k_q + 1'b1;
          ret_q   <= (k_q == FW'(5)) ? S_CRC_LO : S_MW_HDR;
          state_q <= S_EMIT;
        end
        S_DONE: begin
          fill_q  <= '0;
          ovf_q   <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign payload_o      = payload_q;
  assign last_o         = last_q;

  // Frame store never counts past its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(RX_BYTES))
    else $error("frame store fill beyond depth");

  // Last marks only a transmitted response word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> (result_valid_o && !kind_o))
    else $error("last without a response word");

  // A local read is answered with a local result word after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o &&
     (command_i == CMD_READ_HOLDING || command_i == CMD_READ_COIL))
    |-> ##2 (result_valid_o && kind_o))
    else $error("local read word missing");

  // A finished frame leaves the store empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (fill_q == '0 && !ovf_q))
    else $error("frame store not emptied");

endmodule

// File: bench/frame_checker.sv
package mbrs_line_pkg;
  import mbrs_pkg::*;

  // Advance the line CRC by one byte.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] data);
    int k;
    crc ^= {8'h00, data};
    for (k = 0; k < 8; k++) begin
      crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction
endpackage

module frame_checker
  import mbrs_pkg::*;
  import mbrs_line_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  address_i,
  input  logic [15:0] value_i,
  input  logic        result_valid_o,
  input  logic        kind_o,
  input  logic [15:0] payload_o,
  input  logic        last_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          fail_count,
  output int          pending,
  output int          words_checked
);

  localparam int unsigned N_TAB  = TABLE_ENTRIES_DEF;
  localparam int unsigned N_RX   = RX_BYTES_DEF;
  localparam int unsigned MAX_RSP = MAX_RESPONSE_BYTES_DEF;

  typedef struct packed {
    logic        kind;
    logic [15:0] payload;
    logic        last;
  } word_t;

  word_t       expected_words[$];
  logic [7:0]  station;
  logic        crc_en;
  logic [7:0]  rx_bytes[N_RX];
  int unsigned rx_fill;
  logic        rx_ovf;
  logic        coils[N_TAB];
  logic        discs[N_TAB];
  logic [15:0] holding[N_TAB];
  logic [15:0] inputs[N_TAB];
  logic [7:0]  reply[MAX_RSP + 2];

  initial begin
    station = 8'd1;
    crc_en = 1'b1;
    rx_fill = 0;
    rx_ovf = 1'b0;
    fail_count = 0;
    pending = 0;
    words_checked = 0;
    for (int i = 0; i < N_TAB; i++) begin
      coils[i] = 1'b0;
      discs[i] = 1'b0;
      holding[i] = '0;
      inputs[i] = '0;
    end
    for (int i = 0; i < N_RX; i++) rx_bytes[i] = '0;
  end

  function automatic logic [7:0] frame_byte(int unsigned i);
    return (i < rx_fill && i < N_RX) ? rx_bytes[i] : 8'h00;
  endfunction

  function automatic logic [15:0] frame_word(int unsigned i);
    return {frame_byte(i), frame_byte(i + 1)};
  endfunction

  function automatic void emit_reply(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      expected_words.push_back('{kind: 1'b0, payload: {8'h00, reply[k]}, last: (k + 1 == n)});
    end
  endfunction

  function automatic void emit_with_crc(int unsigned n);
    logic [15:0] c;
    c = CRC_INIT;
    for (int unsigned k = 0; k < n; k++) c = crc16_step(c, reply[k]);
    reply[n] = c[7:0];
    reply[n + 1] = c[15:8];
    emit_reply(n + 2);
  endfunction

  function automatic void serve_frame();
    int unsigned len, start, cnt, nb, i, j, idx;
    logic [7:0]  code;
    logic [15:0] c, got, w;
    len = rx_fill;
    if (len < 3 || rx_ovf) return;
    if (crc_en) begin
      c = CRC_INIT;
      for (i = 0; i < len - 2; i++) c = crc16_step(c, rx_bytes[i]);
      got = {frame_byte(len - 1), frame_byte(len - 2)};
      if (c != got) return;
    end
    if (frame_byte(0) != station) return;
    code = frame_byte(1);
    start = frame_word(2);
    cnt = frame_word(4);
    for (i = 0; i < MAX_RSP + 2; i++) reply[i] = 8'h00;
    case (code)
      FC_READ_COILS, FC_READ_DISCRETE: begin
        nb = (cnt + 7) / 8;
        if (5 + nb > MAX_RSP) return;
        reply[0] = frame_byte(0);
        reply[1] = code;
        reply[2] = nb[7:0];
        for (i = 0; i < cnt; i++) begin
          idx = (start + i) & 32'hFFFF;
          if (idx < N_TAB) begin
            reply[3 + i / 8] |= 8'((code == FC_READ_COILS ? coils[idx] : discs[idx])) << (i % 8);
          end
        end
        emit_with_crc(3 + nb);
      end
      FC_READ_HOLDING, FC_READ_INPUT: begin
        if (5 + 2 * cnt > MAX_RSP) return;
        reply[0] = frame_byte(0);
        reply[1] = code;
        reply[2] = 8'(2 * cnt);
        for (i = 0; i < cnt; i++) begin
          j = ((i ^ 1) < cnt) ? (i ^ 1) : i;
          idx = (start + j) & 32'hFFFF;
          w = (idx < N_TAB) ? (code == FC_READ_HOLDING ? holding[idx] : inputs[idx]) : 16'h0;
          reply[3 + 2 * i] = w[15:8];
          reply[4 + 2 * i] = w[7:0];
        end
        emit_with_crc(3 + 2 * cnt);
      end
      FC_WRITE_COIL, FC_WRITE_REG: begin
        if (len > MAX_RSP) return;
        if (start < N_TAB) begin
          if (code == FC_WRITE_COIL) coils[start] = (cnt != 0);
          else holding[start] = cnt[15:0];
        end
        for (i = 0; i < len; i++) reply[i] = frame_byte(i);
        emit_reply(len);
      end
      FC_WRITE_COILS, FC_WRITE_REGS: begin
        for (i = 0; i < cnt; i++) begin
          idx = (start + i) & 32'hFFFF;
          if (idx < N_TAB) begin
            if (code == FC_WRITE_COILS) begin
              w = {8'h00, frame_byte(7 + i / 8)};
              coils[idx] = w[i % 8];
            end else begin
              j = ((i ^ 1) < cnt) ? (i ^ 1) : i;
              holding[idx] = frame_word(7 + 2 * j);
            end
          end
        end
        for (i = 0; i < 6; i++) reply[i] = frame_byte(i);
        emit_with_crc(6);
      end
      default: ;
    endcase
  endfunction

  function automatic void take_command(logic [2:0] cmd, logic [7:0] addr, logic [15:0] val);
    case (cmd)
      CMD_RX_BYTE: begin
        if (rx_fill < N_RX) begin
          rx_bytes[rx_fill] = val[7:0];
          rx_fill++;
        end else begin
          rx_ovf = 1'b1;
        end
      end
      CMD_FRAME_GAP: begin
        serve_frame();
        rx_fill = 0;
        rx_ovf = 1'b0;
      end
      CMD_SET_INPUT:    inputs[addr] = val;
      CMD_SET_DISCRETE: discs[addr] = (val != 0);
      CMD_READ_HOLDING: expected_words.push_back('{kind: 1'b1, payload: holding[addr], last: 1'b0});
      CMD_READ_COIL:    expected_words.push_back('{kind: 1'b1, payload: {15'h0, coils[addr]},
                                                   last: 1'b0});
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    word_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          $error("unexpected word: kind %0d payload %h last %0d", kind_o, payload_o, last_o);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_o);
            fail_count++;
          end
          if (payload_o !== want.payload) begin
            $error("payload: expected %h, got %h", want.payload, payload_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_STATION: station = cfg_data_i;
          REG_CRC_EN:  crc_en = cfg_data_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) take_command(command_i, address_i, value_i);
      pending = expected_words.size();
    end
  end

endmodule

// File: bench/testbench.sv
module testbench;
  import mbrs_pkg::*;
  import mbrs_line_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  command = CMD_RX_BYTE;
  logic [7:0]  address = '0;
  logic [15:0] value = '0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_index = REG_STATION;
  logic [7:0]  cfg_data = '0;
  logic        busy, result_valid, kind, last, cfg_ready;
  logic [15:0] payload;
  int          fail_count, pending, words_checked;

  int          cycles = 0;
  int          frames_sent = 0;
  int          locals_sent = 0;
  bit          idle_en = 1'b1;
  logic [7:0]  cur_station = 8'd1;
  logic [7:0]  frame_bytes[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  modbus_rtu_slave_engine dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .command_i(command), .address_i(address), .value_i(value),
    .result_valid_o(result_valid), .kind_o(kind), .payload_o(payload), .last_o(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  frame_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .command_i(command), .address_i(address), .value_i(value),
    .result_valid_o(result_valid), .kind_o(kind), .payload_o(payload), .last_o(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
  );

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[modbus_rtu_slave_engine] ERROR");
      $finish;
    end
  end

  // Issue one command word. Called at a falling edge; returns at the falling
  // edge after the accepting rising edge, with start still high so that a
  // following word can go back to back. busy only moves on a rising edge, so
  // its value here decides whether the coming edge takes the word.
  task automatic send_word(logic [2:0] cmd, logic [7:0] addr, logic [15:0] val);
    bit ok;
    if (idle_en && $urandom_range(99) < 21) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start = 1'b1;
    command = cmd;
    address = addr;
    value = val;
    do begin
      ok = !busy;
      @(negedge clk);
    end while (!ok);
  endtask

  // Hold off until every expected word has come and the engine is idle again;
  // dropped frames give no word, so busy covers the rest of their work.
  task automatic drain();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    bit ok;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do begin
      ok = cfg_ready;
      @(negedge clk);
    end while (!ok);
    cfg_valid = 1'b0;
  endtask

  function automatic void append_crc();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_bytes[i]) c = crc16_step(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endfunction

  // Build a well-formed request; for codes 5 and 6 cnt carries the value.
  function automatic void build_request(logic [7:0] code, logic [15:0] first, logic [15:0] cnt);
    int unsigned nb;
    frame_bytes.delete();
    frame_bytes.push_back(cur_station);
    frame_bytes.push_back(code);
    frame_bytes.push_back(first[15:8]);
    frame_bytes.push_back(first[7:0]);
    frame_bytes.push_back(cnt[15:8]);
    frame_bytes.push_back(cnt[7:0]);
    if (code == FC_WRITE_COILS || code == FC_WRITE_REGS) begin
      nb = (code == FC_WRITE_COILS) ? (cnt + 7) / 8 : 2 * cnt;
      frame_bytes.push_back(nb[7:0]);
      repeat (nb) frame_bytes.push_back(8'($urandom));
    end
    append_crc();
  endfunction

  // Stream the frame bytes with random upper bits and close it with a gap.
  task automatic send_frame();
    foreach (frame_bytes[i]) send_word(CMD_RX_BYTE, 8'($urandom), {8'($urandom), frame_bytes[i]});
    send_word(CMD_FRAME_GAP, 8'($urandom), 16'($urandom));
    frames_sent++;
  endtask

  task automatic send_local(logic [2:0] cmd, logic [7:0] addr, logic [15:0] val);
    send_word(cmd, addr, val);
    locals_sent++;
  endtask

  task automatic directed_part();
    // Reads straight after reset see the cleared tables.
    build_request(FC_READ_HOLDING, 16'd0, 16'd2);            send_frame();
    build_request(FC_WRITE_REG, 16'd0, 16'hFFFF);            send_frame();
    build_request(FC_WRITE_COIL, 16'd255, 16'hFF00);         send_frame();
    build_request(FC_WRITE_COIL, 16'd3, 16'h0001);           send_frame();
    // Odd register count: the last one stays unswapped.
    build_request(FC_WRITE_REGS, 16'd10, 16'd3);             send_frame();
    build_request(FC_READ_HOLDING, 16'd10, 16'd3);           send_frame();
    // Coil writes running off the end of the table.
    build_request(FC_WRITE_COILS, 16'd250, 16'd12);          send_frame();
    build_request(FC_READ_COILS, 16'd250, 16'd12);           send_frame();
    send_local(CMD_SET_DISCRETE, 8'd7, 16'd5);
    send_local(CMD_SET_INPUT, 8'd255, 16'hFFFF);
    send_local(CMD_SET_INPUT, 8'd254, 16'h0000);
    build_request(FC_READ_DISCRETE, 16'd0, 16'd16);          send_frame();
    build_request(FC_READ_INPUT, 16'd254, 16'd2);            send_frame();
    send_local(CMD_READ_HOLDING, 8'd0, 16'hFFFF);
    send_local(CMD_READ_COIL, 8'd255, 16'h0000);
    send_local(3'd6, 8'hFF, 16'hFFFF);
    send_local(3'd7, 8'h00, 16'h0000);
    // Start index wraps through 65535 to 0.
    build_request(FC_READ_HOLDING, 16'hFFFF, 16'd2);         send_frame();
    build_request(FC_READ_COILS, 16'd0, 16'd0);              send_frame();
    // Drops: too long a reply, unknown code, wrong station, bad CRC, short.
    build_request(FC_READ_HOLDING, 16'd0, 16'd30);           send_frame();
    build_request(8'h07, 16'd0, 16'd1);                      send_frame();
    build_request(FC_READ_HOLDING, 16'd0, 16'd1);
    frame_bytes[0] = 8'h02;
    send_frame();
    build_request(FC_READ_HOLDING, 16'd0, 16'd1);
    frame_bytes[7] ^= 8'h80;
    send_frame();
    frame_bytes = '{8'h01, 8'h03};
    send_frame();
    frame_bytes.delete();
    send_frame();
    // Overflow: one byte past the store, then the gap drops it.
    build_request(FC_READ_HOLDING, 16'd0, 16'd1);
    while (frame_bytes.size() < RX_BYTES_DEF + 1) frame_bytes.push_back(8'($urandom));
    send_frame();
  endtask

  task automatic random_item();
    logic [7:0]  codes[8];
    logic [7:0]  code;
    logic [15:0] first, cnt;
    int          r, sel;
    codes = '{FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
              FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS};
    r = $urandom_range(99);
    sel = $urandom_range(9);
    first = (sel < 6) ? 16'($urandom_range(255)) :
            (sel < 8) ? 16'($urandom_range(240, 300)) : 16'($urandom_range(65520, 65535));
    if (r < 65) begin
      code = codes[$urandom_range(7)];
      case (code)
        FC_READ_COILS, FC_READ_DISCRETE:
          cnt = ($urandom_range(9) == 0) ? 16'($urandom_range(400, 700)) : 16'($urandom_range(40));
        FC_READ_HOLDING, FC_READ_INPUT: cnt = 16'($urandom_range(32));
        FC_WRITE_COILS, FC_WRITE_REGS:  cnt = 16'($urandom_range(24));
        default: cnt = $urandom_range(3) == 0 ? 16'h0 : 16'($urandom);
      endcase
      build_request(code, first, cnt);
      send_frame();
    end else if (r < 85) begin
      send_local(3'($urandom_range(2, 7)), 8'($urandom),
                 $urandom_range(1) ? 16'h0 : 16'($urandom));
    end else begin
      // Broken frames, built from a short read so nothing runs long.
      build_request(8'($urandom_range(1, 4)), first, 16'($urandom_range(8)));
      case ($urandom_range(3))
        0: frame_bytes[frame_bytes.size() - 1] ^= 8'(1 << $urandom_range(7));
        1: frame_bytes[0] = cur_station ^ 8'($urandom_range(1, 255));
        2: repeat ($urandom_range(1, frame_bytes.size() - 1)) void'(frame_bytes.pop_back());
        default: begin
          frame_bytes.delete();
          frame_bytes.push_back(cur_station ^ 8'h01);
          repeat ($urandom_range(8)) frame_bytes.push_back(8'($urandom));
        end
      endcase
      send_frame();
    end
  endtask

  initial begin
    logic [7:0] stations[4];
    logic       crc_modes[4];
    stations  = '{8'h00, 8'hFF, 8'($urandom), 8'h01};
    crc_modes = '{1'b0, 1'b1, 1'($urandom), 1'b1};

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    directed_part();

    // Step through the settings; the drain before each is the pause that lets
    // every outstanding word come home, and the third runs with no idling.
    for (int p = 0; p < 4; p++) begin
      drain();
      cur_station = stations[p];
      write_reg(REG_STATION, stations[p]);
      write_reg(REG_CRC_EN, {7'h0, crc_modes[p]});
      idle_en = (p != 2);
      repeat (25) random_item();
    end
    drain();

    $display("Covered %0d frames and %0d local commands over four settings,", frames_sent,
             locals_sent);
    $display("checking %0d result words against the prediction.", words_checked);
    if (fail_count == 0) begin
      $display("[modbus_rtu_slave_engine] OK");
    end else begin
      $display("[modbus_rtu_slave_engine] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mbrs_pkg.sv
sv/mbrs_crc.sv
sv/modbus_rtu_slave_engine.sv
bench/frame_checker.sv
bench/testbench.sv
